[design/u8u16_pkg.sv]
// Shared constants and types for the UTF-8 to UTF-16 decoder.
// No dependencies.
`default_nettype none

package u8u16_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned UnitW = 16;
    localparam int unsigned CountW = 2;

    localparam logic [ByteW-1:0] LeadAsciiLimit = 8'h80;
    localparam logic [2:0] Lead2Tag = 3'h6;
    localparam logic [3:0] Lead3Tag = 4'hE;
    localparam logic [10:0] Lead2Mask = 11'h7FF;
    localparam logic [5:0] ContMask = 6'h3F;
    localparam logic [UnitW-1:0] Lead3Mask = 16'hFFFF;
    localparam logic [11:0] Mid3Mask = 12'hFFF;

    localparam logic [CountW-1:0] PendIdle = 2'd0;
    localparam logic [CountW-1:0] PendLast = 2'd1;
    localparam logic [CountW-1:0] PendMid = 2'd2;

    typedef struct packed {
        logic [UnitW-1:0] code_unit;
        logic             is_error;
        logic             string_end;
    } u8u16_result_t;

endpackage

`default_nettype wire

[design/utf8_to_utf16_decoder_unit.sv]
// Top level of the UTF-8 to UTF-16 decoder (basic multilingual plane).
// Depends on u8u16_pkg.
//
// Usage:
//   Input channel: in_valid / in_stall with byte_value, one UTF-8 byte per beat.
//   Output channel: out_valid / out_stall with code_unit, is_error, string_end.
//   A beat moves when valid is high and stall is low at a rising clk edge.
//   Each accepted byte lands in an input register; the decode logic then
//   writes the output register, so a result is registered in the output
//   register once its final byte has left the input register. Lead and
//   middle bytes of a multi-byte sequence give no result. One byte per cycle
//   is sustained while the receiver does not stall, set by the single decode pass.
//   ASCII bytes pass through; a zero lead byte gives a string_end beat; an
//   invalid lead byte gives an is_error beat and the decoder returns to idle.
//   When the receiver stalls with a result held, the input register holds
//   and in_stall rises once that register is full; nothing is dropped.
//   Reset (rst_n low, asynchronous) empties both registers and returns the
//   decoder to idle with a cleared partial value.
`default_nettype none

module utf8_to_utf16_decoder_unit
    import u8u16_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [ByteW-1:0] byte_value,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [UnitW-1:0]      code_unit,
    output logic                  is_error,
    output logic                  string_end
);

    logic              in_valid_reg;
    logic [ByteW-1:0]  byte_reg;
    logic [CountW-1:0] pending_count_reg;
    logic [CountW-1:0] pending_count_next;
    logic [UnitW-1:0]  partial_value_reg;
    logic [UnitW-1:0]  partial_value_next;
    logic              out_valid_reg;
    u8u16_result_t     result_reg;
    u8u16_result_t     result_next;
    logic              emit;
    logic              advance;
    logic              load_in;

    assign advance = !out_valid_reg || !out_stall;
    assign load_in = !in_valid_reg || advance;
    assign in_stall = !load_in;

    always_comb
    begin
        pending_count_next = pending_count_reg;
        partial_value_next = partial_value_reg;
        emit = 1'b0;
        result_next = '0;
        case (pending_count_reg)
            PendIdle:
            begin
                if (byte_reg == '0)
                begin
                    emit = 1'b1;
                    result_next.string_end = 1'b1;
                end
                else if (byte_reg < LeadAsciiLimit)
                begin
                    emit = 1'b1;
                    result_next.code_unit = {{(UnitW-ByteW){1'b0}}, byte_reg};
                end
                else if (byte_reg[7:5] == Lead2Tag)
                begin
                    partial_value_next = {5'd0, ({byte_reg[4:0], 6'd0} & Lead2Mask)};
                    pending_count_next = PendLast;
                end
                else if (byte_reg[7:4] == Lead3Tag)
                begin
                    partial_value_next = {byte_reg[3:0], 12'd0} & Lead3Mask;
                    pending_count_next = PendMid;
                end
                else
                begin
                    emit = 1'b1;
                    result_next.is_error = 1'b1;
                end
            end
            PendLast:
            begin
                emit = 1'b1;
                result_next.code_unit = partial_value_reg
                    + {10'd0, byte_reg[5:0] & ContMask};
                pending_count_next = PendIdle;
                partial_value_next = '0;
            end
            default:
            begin
                partial_value_next = partial_value_reg
                    + {4'd0, {byte_reg[5:0], 6'd0} & Mid3Mask};
                pending_count_next = PendLast;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            pending_count_reg <= PendIdle;
            partial_value_reg <= '0;
        end
        else
        begin
            if (load_in)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg && emit;
                if (in_valid_reg)
                begin
                    pending_count_reg <= pending_count_next;
                    partial_value_reg <= partial_value_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            byte_reg <= byte_value;
        end
        if (advance && in_valid_reg && emit)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign code_unit = result_reg.code_unit;
    assign is_error = result_reg.is_error;
    assign string_end = result_reg.string_end;

    a_special_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (is_error || string_end) |-> code_unit == '0)
        else $error("special result carries nonzero code unit");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_error && string_end))
        else $error("error and end flags both set");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        pending_count_reg != 2'd3)
        else $error("pending count out of range");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(code_unit))
        else $error("held result changed");

endmodule

`default_nettype wire
